@@ rtl/core/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, register codes and types for the byte pattern search.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int PATTERN_MAX = 16;   // pattern bytes compared per alignment
  localparam int OFFSET_BITS = 32;   // width of the per-region byte count

  localparam int WIN_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W      = $clog2(PATTERN_MAX + 1);
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_LEN_W  = 5;
  localparam int MASK_W     = 16;
  localparam int OFF_OUT_W  = 32;
  localparam int OFF_EXT_W  = (OFFSET_BITS > OFF_OUT_W) ? OFFSET_BITS : OFF_OUT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO    = 2'd0,
    REG_PAT_HI    = 2'd1,
    REG_WILD_MASK = 2'd2,
    REG_PAT_LEN   = 2'd3
  } cfg_reg_e;

  // Decoded pattern setup, length already clamped to 1..PATTERN_MAX
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [PATTERN_MAX-1:0]      wild;
    logic [LEN_W-1:0]            len;
  } pat_cfg_t;

  // Outcome of one byte step
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [OFF_OUT_W-1:0] match_offset;
  } match_res_t;

endpackage

@@ rtl/core/bps_in_if.sv @@
// ----------------------------------------------------------------------------
// bps_in_if
// Byte stream request channel: valid/ready with one byte and end marker.
// ----------------------------------------------------------------------------
interface bps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/bps_out_if.sv @@
// ----------------------------------------------------------------------------
// bps_out_if
// Search result channel: valid/ready with found flag and match offset.
// ----------------------------------------------------------------------------
interface bps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

@@ rtl/core/wildcard_byte_pattern_search.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Scans a byte stream for the first match of a masked pattern of up to
// PATTERN_MAX bytes and reports found / not-found once per region.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      data_byte[7:0], last_byte
//  out_ch    out  valid / ready      found, match_offset[31:0]
//  cfg       in   cfg_we_i           cfg_idx_i[1:0], cfg_wdata_i[63:0]
//
//  One byte per cycle sustained unless a stalled result has filled both
//  registers; a byte is held in the input register, then compared, and its
//  result is loaded into the result register, from which it is taken.
//  The compare is 16 byte comparators on the shifted window, AND-reduced.
//  A stalled result only blocks input once both registers are full.
//  Reset clears the region count, valid flags and config (length = 1).
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search
  import bps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bps_in_if.sink                in_ch,
  bps_out_if.source             out_ch
);

  pat_cfg_t   cfg;
  match_res_t res;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // result register
  logic                 out_valid_q;
  logic                 out_found_q;
  logic [OFF_OUT_W-1:0] out_off_q;

  logic out_free;
  logic adv;
  logic accept;

  bps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bps_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (adv),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .res_o       (res)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free    = !out_valid_q || out_ch.ready;
  // stage 1 moves on whether or not the byte produces a result
  assign adv         = s1_valid_q && out_free;
  assign in_ch.ready = !s1_valid_q || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_ch.data_byte;
      s1_last_q <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_found_q <= res.found;
      out_off_q   <= res.match_offset;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.found        = out_found_q;
  assign out_ch.match_offset = out_off_q;

`ifndef SYNTHESIS
  a_notfound_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.found |-> out_ch.match_offset == '0)
    else $error("not-found result with nonzero offset");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> s1_valid_q && out_valid_q && !out_ch.ready)
    else $error("input stalled with room in the pipe");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.valid |=> out_ch.valid)
    else $error("result lost on advance");
`endif

endmodule

@@ rtl/core/bps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Pattern, wildcard mask and length registers with length clamping.
// ----------------------------------------------------------------------------
module bps_cfg_regs
  import bps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output pat_cfg_t              cfg_o
);

  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [MASK_W-1:0]     mask_q;
  logic [CFG_LEN_W-1:0]  len_q;
  logic [2*CFG_DATA_W-1:0] pat_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      mask_q   <= '0;
      len_q    <= CFG_LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_LO:    pat_lo_q <= cfg_wdata_i;
        REG_PAT_HI:    pat_hi_q <= cfg_wdata_i;
        REG_WILD_MASK: mask_q   <= cfg_wdata_i[MASK_W-1:0];
        REG_PAT_LEN:   len_q    <= cfg_wdata_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      cfg_o.pattern[k] = pat_all[8*k +: 8];
      cfg_o.wild[k]    = mask_q[k];
    end
    // zero means one, anything past the window means a full window
    if (len_q == '0) begin
      cfg_o.len = LEN_W'(1);
    end else if (len_q > CFG_LEN_W'(PATTERN_MAX)) begin
      cfg_o.len = LEN_W'(PATTERN_MAX);
    end else begin
      cfg_o.len = LEN_W'(len_q);
    end
  end

endmodule

@@ rtl/core/bps_match.sv @@
// ----------------------------------------------------------------------------
// bps_match
// Byte window, region count and parallel wildcard comparators.
// ----------------------------------------------------------------------------
module bps_match
  import bps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pat_cfg_t   cfg_i,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output match_res_t res_o
);

  logic [PATTERN_MAX-1:0][7:0] window_q;
  logic [PATTERN_MAX-1:0][7:0] window_d;
  logic [OFFSET_BITS-1:0]      seen_q;
  logic [OFFSET_BITS-1:0]      seen_inc;
  logic                        reported_q;
  logic [LEN_W-1:0]            tap_idx [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      pos_ok;
  logic                        long_enough;
  logic                        hit;
  logic [OFF_EXT_W-1:0]        off_ext;

  // newest byte enters at entry 0
  always_comb begin
    window_d[0] = data_byte_i;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_d[j] = window_q[j-1];
    end
  end

  assign seen_inc    = (seen_q == '1) ? seen_q : seen_q + OFFSET_BITS'(1);
  assign long_enough = seen_inc >= OFFSET_BITS'(cfg_i.len);

  // pattern byte k lines up with window entry len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      tap_idx[k] = cfg_i.len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) >= cfg_i.len) begin
        pos_ok[k] = 1'b1;
      end else begin
        pos_ok[k] = cfg_i.wild[k] ||
                    (window_d[tap_idx[k][WIN_IDX_W-1:0]] == cfg_i.pattern[k]);
      end
    end
  end

  assign hit     = !reported_q && long_enough && (&pos_ok);
  assign off_ext = OFF_EXT_W'(seen_inc) - OFF_EXT_W'(cfg_i.len);

  always_comb begin
    res_o.valid = hit || (last_byte_i && !reported_q);
    res_o.found = hit;
    if (!hit) begin
      res_o.match_offset = '0;
    end else if (off_ext > OFF_EXT_W'({OFF_OUT_W{1'b1}})) begin
      res_o.match_offset = '1;
    end else begin
      res_o.match_offset = off_ext[OFF_OUT_W-1:0];
    end
  end

  // window entries beyond the count are never compared: no reset needed
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        seen_q     <= seen_inc;
        reported_q <= reported_q | hit;
      end
    end
  end

`ifndef SYNTHESIS
  a_hit_sets_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && hit && !last_byte_i |=> reported_q)
    else $error("match not recorded");

  a_reported_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> seen_q != '0)
    else $error("match reported in empty region");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> seen_q == '0 && !reported_q)
    else $error("region not cleared on last byte");
`endif

endmodule

@@ tb/bps_search_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bps_search_checker
// Watches the byte and result channels and the config port of the pattern
// search. Keeps its own copy of the pattern setup and region state, works out
// the result each accepted byte should cause, and compares the results that
// come out against those, in order.
// ----------------------------------------------------------------------------
module bps_search_checker
  import bps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bps_in_if                     in_ch,
  bps_out_if                    out_ch,
  output int                    fail_count_o,
  output int                    awaiting_o
);

  typedef struct packed {
    logic                 found;
    logic [OFF_OUT_W-1:0] offset;
  } search_outcome_t;

  // pattern setup as last written
  logic [2*CFG_DATA_W-1:0] pattern_q;
  logic [MASK_W-1:0]       wild_q;
  logic [CFG_LEN_W-1:0]    len_q;

  // region state
  logic [7:0]             window_q [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] region_count_q;
  logic                   reported_q;

  search_outcome_t outcome_fifo [$];

  task automatic clear_region();
    int k;
    for (k = 0; k < PATTERN_MAX; k++) window_q[k] = 8'h00;
    region_count_q = '0;
    reported_q     = 1'b0;
  endtask

  // Advance the region by one byte, queue the outcome it causes, if any.
  task automatic scan_byte(input logic [7:0] b, input logic region_end);
    int                   span;
    int                   k;
    logic                 hit;
    logic [OFF_EXT_W-1:0] off;
    search_outcome_t      res;
    span = (len_q == 0) ? 1 : ((len_q > PATTERN_MAX) ? PATTERN_MAX : int'(len_q));
    for (k = PATTERN_MAX - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    if (region_count_q != '1) region_count_q = region_count_q + 1'b1;

    hit = 1'b0;
    if (!reported_q && region_count_q >= span) begin
      hit = 1'b1;
      for (k = 0; k < span; k++) begin
        if (!wild_q[k] && window_q[span-1-k] != pattern_q[8*k +: 8]) hit = 1'b0;
      end
    end

    if (hit) begin
      off = OFF_EXT_W'(region_count_q) - OFF_EXT_W'(span);
      res.found  = 1'b1;
      res.offset = ((off >> OFF_OUT_W) != 0) ? '1 : off[OFF_OUT_W-1:0];
      outcome_fifo.insert(outcome_fifo.size(), res);
      reported_q = 1'b1;
      if (region_end) clear_region();
    end else if (region_end) begin
      if (!reported_q) begin
        res.found  = 1'b0;
        res.offset = '0;
        outcome_fifo.insert(outcome_fifo.size(), res);
      end
      clear_region();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q = '0;
      wild_q    = '0;
      len_q     = CFG_LEN_W'(1);
      clear_region();
      outcome_fifo.delete();
      awaiting_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAT_LO:    pattern_q[CFG_DATA_W-1:0] = cfg_wdata_i;
          REG_PAT_HI:    pattern_q[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_wdata_i;
          REG_WILD_MASK: wild_q = cfg_wdata_i[MASK_W-1:0];
          REG_PAT_LEN:   len_q = cfg_wdata_i[CFG_LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (outcome_fifo.size() == 0) begin
          $error("unexpected result: found %0d, match_offset %0d",
                 out_ch.found, out_ch.match_offset);
          fail_count_o++;
        end else begin
          search_outcome_t want;
          want = outcome_fifo.pop_front();
          if (out_ch.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_ch.found);
            fail_count_o++;
          end
          if (out_ch.match_offset !== want.offset) begin
            $error("match_offset: expected %0d, actual %0d",
                   want.offset, out_ch.match_offset);
            fail_count_o++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.last_byte);

      awaiting_o = outcome_fifo.size();
    end
  end

endmodule

@@ tb/wildcard_byte_pattern_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_tb
// Drives byte regions into the pattern search under a series of pattern
// setups, with random gaps and result back-pressure, and gives the verdict
// from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_tb;
  import bps_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result
  localparam int HOLD_CYCLES    = 60;    // one long result stall
  localparam int DRAIN_CYCLES   = 4;     // input reg + result reg, with margin
  localparam int RANDOM_ITEMS   = 560;
  localparam int TAIL_ITEMS     = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();

  int fail_count;
  int awaiting;

  // stimulus-side view of the current setup, used only to plant matches
  logic [2*CFG_DATA_W-1:0] cur_pattern;
  logic [MASK_W-1:0]       cur_mask;
  logic [CFG_LEN_W-1:0]    cur_len;

  int requests_sent;
  bit gaps_on;    // random idle bursts on both channels
  bit hold_req;   // ask the result side for its long stall
  bit hold_done;
  int quiet_cycles;

  wildcard_byte_pattern_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  bps_search_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count_o(fail_count),
    .awaiting_o  (awaiting)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus one long hold-off when
  // the stimulus asks for it. The hold is counted here, so the sender keeps
  // offering bytes and the block has to back up into its input.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // pattern bytes in use, with the length clamp applied
  function automatic int span_of(input logic [CFG_LEN_W-1:0] n);
    return (n == 0) ? 1 : ((n > PATTERN_MAX) ? PATTERN_MAX : int'(n));
  endfunction

  // One byte request; an idle burst may come first. Returns right after the
  // edge that accepted it, with valid still high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic region_end);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= region_end;
    do @(posedge clk_i); while (!in_ch.ready);
    requests_sent++;
  endtask

  // Let every expected result out and the pipeline empty, then reprogram.
  // All four registers go back to back so write enable is raised once.
  task automatic load_setup(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input logic [MASK_W-1:0] mask, input logic [CFG_LEN_W-1:0] n);
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PAT_LO;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PAT_HI;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= REG_WILD_MASK;
    cfg_wdata_i <= CFG_DATA_W'(mask);
    @(posedge clk_i);
    cfg_idx_i   <= REG_PAT_LEN;
    cfg_wdata_i <= CFG_DATA_W'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_pattern = {hi, lo};
    cur_mask    = mask;
    cur_len     = n;
  endtask

  // A region of n bytes. Content leans on pattern bytes so partial matches
  // are common; plant drops a full copy in at a random spot, spoil then
  // flips one bit of it to make a near miss.
  task automatic send_region(input int n, input bit plant, input bit spoil);
    logic [7:0] region_bytes [64];
    int         span;
    int         at;
    int         k;
    span = span_of(cur_len);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0) region_bytes[k] = 8'($urandom);
      else region_bytes[k] = cur_pattern[8*$urandom_range(0, span - 1) +: 8];
    end
    if (plant && n >= span) begin
      at = $urandom_range(0, n - span);
      for (k = 0; k < span; k++) begin
        if (!cur_mask[k]) region_bytes[at+k] = cur_pattern[8*k +: 8];
      end
      if (spoil) begin
        k = at + $urandom_range(0, span - 1);
        region_bytes[k] = region_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (k = 0; k < n; k++) send_byte(region_bytes[k], k == n - 1);
  endtask

  // Random setup for a phase; the first two are the extremes.
  task automatic pick_setup(input int phase);
    logic [CFG_LEN_W-1:0] n;
    logic [MASK_W-1:0]    mask;
    if (phase == 0) begin
      load_setup('0, '0, '0, CFG_LEN_W'(PATTERN_MAX));
    end else if (phase == 1) begin
      load_setup('1, '1, '1, '1);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = CFG_LEN_W'($urandom_range(1, 4));
        6, 7, 8:          n = CFG_LEN_W'($urandom_range(5, PATTERN_MAX));
        default:          n = CFG_LEN_W'($urandom_range(0, 31));
      endcase
      // sparse wildcards, sometimes none at all
      mask = ($urandom_range(0, 3) == 0) ? '0 : MASK_W'($urandom & $urandom & $urandom);
      load_setup({$urandom, $urandom}, {$urandom, $urandom}, mask, n);
    end
  endtask

  // A run of well-formed regions of random sizes; a few are long.
  task automatic run_regions(input int count);
    int stop_at;
    int span;
    int n;
    stop_at = requests_sent + count;
    span    = span_of(cur_len);
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 60);
      else n = $urandom_range(1, span + 8);
      send_region(n, $urandom_range(0, 9) < 7, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int phase;
    int k;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_PAT_LO;
    cfg_wdata_i     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    cur_pattern   = '0;
    cur_mask      = '0;
    cur_len       = CFG_LEN_W'(1);
    requests_sent = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed ----------------
    // Reset setup: one pattern byte 0x00, no wildcards.
    send_byte(8'h00, 1'b1);          // match on the last byte: found only
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);          // found at offset 1
    send_byte(8'hFF, 1'b1);          // end after a report: nothing

    // AA ?? CC with position 1 wild; mask bit 10 lies beyond the length
    load_setup(64'h0000_0000_00CC_BBAA, '0, 16'h0402, CFG_LEN_W'(3));
    send_byte(8'hAA, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hCC, 1'b0);          // wildcard match at offset 0
    send_byte(8'hAA, 1'b1);          // later bytes of the region are quiet
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b1);          // region shorter than pattern: not found

    // length 0 acts as 1
    load_setup('1, '1, '0, '0);
    send_byte(8'hFF, 1'b1);

    // length 31 clamps to 16, every position wild: match on the 16th byte
    load_setup('1, '1, '1, 5'd31);
    for (k = 0; k < PATTERN_MAX; k++) send_byte(8'($urandom), k == PATTERN_MAX - 1);

    // ---------------- random ----------------
    phase = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      gaps_on = (phase % 3) != 1;   // every third phase runs back to back
      if (phase == 2) begin
        // Single-byte regions, pattern length 1: every byte gives a result,
        // so a long result stall backs the block up into its input.
        load_setup({$urandom, $urandom}, {$urandom, $urandom},
                   MASK_W'($urandom_range(0, 1)), CFG_LEN_W'(1));
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++) send_byte(8'($urandom), 1'b1);
      end else begin
        pick_setup(phase);
        run_regions($urandom_range(40, 80));
      end
      phase++;
    end

    // last stretch with no idling on either side
    gaps_on = 1'b0;
    pick_setup(phase);
    run_regions(TAIL_ITEMS);

    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bps_pkg.sv
rtl/core/bps_in_if.sv
rtl/core/bps_out_if.sv
rtl/core/bps_cfg_regs.sv
rtl/core/bps_match.sv
rtl/core/wildcard_byte_pattern_search.sv
tb/bps_search_checker.sv
tb/wildcard_byte_pattern_search_tb.sv
